[src/bsdl_pkg.sv]
// Shared types and constants for the bounded sorted deque list core.
// No dependencies; bsdl_ctrl, bsdl_datapath and the top-level core import this package.
`default_nettype none

package bsdl_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int REQ_WIDTH    = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int DEF_CAPACITY = 16;

   // request codes; code 7 is unused and ignored
   typedef enum logic [REQ_WIDTH-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_INSERT     = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_POP_BACK   = 3'd4,
      REQ_REMOVE     = 3'd5,
      REQ_LIST       = 3'd6
   } req_code_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_LIST
   } state_type;

   // how the walk engine is initialized
   typedef enum logic [1:0] {
      SETUP_NONE,
      SETUP_SCAN,
      SETUP_UP,
      SETUP_DOWN
   } setup_type;

   // what the walk engine does in a cycle
   typedef enum logic [1:0] {
      WALK_NONE,
      WALK_ASC,
      WALK_UP,
      WALK_DOWN
   } walk_type;

   // source of the position where the list opens or closes
   typedef enum logic [1:0] {
      POS_ZERO,
      POS_COUNT,
      POS_LAST,
      POS_SCAN
   } pos_sel_type;

   typedef struct packed {
      logic        load;
      setup_type   setup;
      pos_sel_type pos_sel;
      walk_type    walk;
      logic        write_value;
      logic        count_inc;
      logic        count_dec;
      logic        emit;
      status_type  emit_status;
      logic        emit_entry;
      logic        emit_last;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic walk_done;
      logic scan_hit;
      logic scan_end;
      logic list_last;
      logic pend_vld;
      logic op_remove;
   } stat_type;

endpackage

`default_nettype wire

[src/bsdl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bsdl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/bsdl_ctrl.sv]
// Controller state machine: decodes requests and sequences the datapath walks.
// Depends on bsdl_pkg.
`default_nettype none

module bsdl_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [bsdl_pkg::REQ_WIDTH-1:0]    req_type,
   output logic                                   busy,
   input  wire bsdl_pkg::stat_type                stat,
   output bsdl_pkg::cmd_type                      cmd
);

   import bsdl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      busy            = (state_ff != S_IDLE);
      cmd.load        = 1'b0;
      cmd.setup       = SETUP_NONE;
      cmd.pos_sel     = POS_ZERO;
      cmd.walk        = WALK_NONE;
      cmd.write_value = 1'b0;
      cmd.count_inc   = 1'b0;
      cmd.count_dec   = 1'b0;
      cmd.emit        = 1'b0;
      cmd.emit_status = ST_OK;
      cmd.emit_entry  = 1'b0;
      cmd.emit_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_code_type'(req_type))
                  REQ_PUSH_FRONT: begin
                     if (stat.full) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_FULL;
                     end else begin
                        cmd.setup   = SETUP_UP;
                        cmd.pos_sel = POS_ZERO;
                        state_in    = S_SHIFT_UP;
                     end
                  end
                  REQ_PUSH_BACK: begin
                     if (stat.full) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_FULL;
                     end else begin
                        cmd.setup   = SETUP_UP;
                        cmd.pos_sel = POS_COUNT;
                        state_in    = S_SHIFT_UP;
                     end
                  end
                  REQ_INSERT: begin
                     if (stat.full) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_FULL;
                     end else if (stat.count_zero) begin
                        cmd.setup   = SETUP_UP;
                        cmd.pos_sel = POS_ZERO;
                        state_in    = S_SHIFT_UP;
                     end else begin
                        cmd.setup = SETUP_SCAN;
                        state_in  = S_SEARCH;
                     end
                  end
                  REQ_POP_FRONT: begin
                     if (stat.count_zero) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.setup   = SETUP_DOWN;
                        cmd.pos_sel = POS_ZERO;
                        state_in    = S_SHIFT_DOWN;
                     end
                  end
                  REQ_POP_BACK: begin
                     if (stat.count_zero) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.setup   = SETUP_DOWN;
                        cmd.pos_sel = POS_LAST;
                        state_in    = S_SHIFT_DOWN;
                     end
                  end
                  REQ_REMOVE: begin
                     if (stat.count_zero) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.setup = SETUP_SCAN;
                        state_in  = S_SEARCH;
                     end
                  end
                  REQ_LIST: begin
                     if (stat.count_zero) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.setup = SETUP_SCAN;
                        state_in  = S_LIST;
                     end
                  end
                  default: begin
                     cmd.load = 1'b0;
                  end
               endcase
            end
         end

         // scan for the insert position or the entry to remove
         S_SEARCH: begin
            cmd.walk = WALK_ASC;
            if (stat.scan_hit || stat.scan_end) begin
               if (stat.op_remove) begin
                  if (stat.scan_hit) begin
                     cmd.setup   = SETUP_DOWN;
                     cmd.pos_sel = POS_SCAN;
                     state_in    = S_SHIFT_DOWN;
                  end else begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_NOT_FOUND;
                     state_in        = S_IDLE;
                  end
               end else begin
                  cmd.setup   = SETUP_UP;
                  cmd.pos_sel = POS_SCAN;
                  state_in    = S_SHIFT_UP;
               end
            end
         end

         // open a slot, then drop the new value into it
         S_SHIFT_UP: begin
            cmd.walk = WALK_UP;
            if (stat.walk_done) begin
               cmd.write_value = 1'b1;
               cmd.count_inc   = 1'b1;
               cmd.emit        = 1'b1;
               state_in        = S_IDLE;
            end
         end

         // close the slot of the removed entry
         S_SHIFT_DOWN: begin
            cmd.walk = WALK_DOWN;
            if (stat.walk_done) begin
               cmd.count_dec = 1'b1;
               cmd.emit      = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // one transaction per entry
         S_LIST: begin
            cmd.walk = WALK_ASC;
            if (stat.pend_vld) begin
               cmd.emit       = 1'b1;
               cmd.emit_entry = 1'b1;
               cmd.emit_last  = stat.list_last;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/bsdl_datapath.sv]
// Datapath: entry memory, count, walk engine (scan and shift) and result registers.
// Depends on bsdl_pkg and bsdl_ram.
`default_nettype none

module bsdl_datapath #(
   parameter int CAPACITY = bsdl_pkg::DEF_CAPACITY
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic [bsdl_pkg::REQ_WIDTH-1:0]           req_type,
   input  wire logic signed [bsdl_pkg::DATA_WIDTH-1:0]   req_value,
   input  wire bsdl_pkg::cmd_type                        cmd,
   output bsdl_pkg::stat_type                            stat,
   output logic                                          rsp_valid,
   output logic [bsdl_pkg::STATUS_WIDTH-1:0]             rsp_status,
   output logic signed [bsdl_pkg::DATA_WIDTH-1:0]        rsp_entry,
   output logic                                          rsp_last
);

   import bsdl_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // request registers
   logic signed [DATA_WIDTH-1:0] val_ff;
   logic                         op_remove_ff;

   // list state
   logic [CW-1:0] count_ff, count_in;

   // walk engine
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          pend_vld_ff, pend_vld_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [CW-1:0] pos_ff, pos_in;

   // result registers
   logic                         rsp_valid_ff;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff;
   logic signed [DATA_WIDTH-1:0] rsp_entry_ff;
   logic                         rsp_last_ff;

   // memory port signals
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [DATA_WIDTH-1:0] rd_data;

   logic signed [DATA_WIDTH-1:0] rd_s;
   logic [CW-1:0] pend_ext;
   logic [CW-1:0] scan_pos;
   logic [CW-1:0] pos_sel_val;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] pos_p1;
   logic          is_last;
   logic          hit;

   bsdl_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // compare of the returned entry against the request value
   always_comb begin
      rd_s     = $signed(rd_data);
      pend_ext = CW'(pend_addr_ff);
      is_last  = ((pend_ext + CW'(1)) == count_ff);
      if (op_remove_ff) begin
         hit = (rd_s == val_ff);
      end else if (pend_addr_ff == '0) begin
         hit = (val_ff < rd_s);
      end else begin
         hit = !(rd_s < val_ff);
      end
      scan_pos = hit ? pend_ext : (pend_ext + CW'(1));
   end

   // position select
   always_comb begin
      case (cmd.pos_sel)
         POS_ZERO:  pos_sel_val = '0;
         POS_COUNT: pos_sel_val = count_ff;
         POS_LAST:  pos_sel_val = count_ff - CW'(1);
         POS_SCAN:  pos_sel_val = scan_pos;
         default:   pos_sel_val = '0;
      endcase
      cnt_m1 = count_ff - CW'(1);
      pos_p1 = pos_sel_val + CW'(1);
   end

   // walk engine next state
   always_comb begin
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      pend_vld_in  = pend_vld_ff;
      pend_addr_in = pend_addr_ff;
      pos_in       = pos_ff;
      rd_en        = 1'b0;
      if (cmd.setup != SETUP_NONE) begin
         pend_vld_in = 1'b0;
         pos_in      = pos_sel_val;
         case (cmd.setup)
            SETUP_SCAN: begin
               ptr_in = '0;
               rem_in = count_ff;
            end
            SETUP_UP: begin
               ptr_in = cnt_m1[AW-1:0];
               rem_in = count_ff - pos_sel_val;
            end
            SETUP_DOWN: begin
               ptr_in = pos_p1[AW-1:0];
               rem_in = cnt_m1 - pos_sel_val;
            end
            default: begin
               ptr_in = ptr_ff;
            end
         endcase
      end else if (cmd.walk != WALK_NONE) begin
         if (rem_ff != '0) begin
            rd_en        = 1'b1;
            rem_in       = rem_ff - CW'(1);
            ptr_in       = (cmd.walk == WALK_UP) ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
            pend_vld_in  = 1'b1;
            pend_addr_in = ptr_ff;
         end else begin
            pend_vld_in = 1'b0;
         end
      end
   end

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = rd_data;
      if (cmd.write_value) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff[AW-1:0];
         wr_data = val_ff;
      end else if (cmd.walk == WALK_UP && pend_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff + AW'(1);
      end else if (cmd.walk == WALK_DOWN && pend_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff - AW'(1);
      end
   end

   // count update
   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rem_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      pos_ff       <= pos_in;
      if (cmd.load) begin
         val_ff       <= req_value;
         op_remove_ff <= (req_code_type'(req_type) == REQ_REMOVE);
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_entry_ff  <= cmd.emit_entry ? rd_s : '0;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   // status to the controller
   always_comb begin
      stat.count_zero = (count_ff == '0);
      stat.full       = (count_ff >= CW'(CAPACITY));
      stat.walk_done  = (rem_ff == '0) && !pend_vld_ff;
      stat.scan_hit   = pend_vld_ff && hit;
      stat.scan_end   = pend_vld_ff && is_last;
      stat.list_last  = pend_vld_ff && is_last;
      stat.pend_vld   = pend_vld_ff;
      stat.op_remove  = op_remove_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

[src/bounded_sorted_deque_list_core.sv]
// Bounded sorted deque list: an ordered list of up to CAPACITY signed 32-bit values held in
// a RAM with registered read. A request is taken when start is high and busy is low; each
// result is shown for exactly one cycle with rsp_valid high, and the receiver cannot stall
// it. Changes give one transaction; a list request gives one transaction per entry, with
// rsp_last on the final one. Time per request is set by the walk over the RAM, one entry a
// cycle through its single read port; push back and pop back move no entries, and a refused
// or empty request needs no walk. There is no clearing pass after reset.
// Depends on bsdl_pkg, bsdl_ctrl and bsdl_datapath.
`default_nettype none

module bounded_sorted_deque_list_core #(
   parameter int CAPACITY = bsdl_pkg::DEF_CAPACITY
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic [bsdl_pkg::REQ_WIDTH-1:0]           req_type,
   input  wire logic signed [bsdl_pkg::DATA_WIDTH-1:0]   req_value,
   output logic                                          rsp_valid,
   output logic [bsdl_pkg::STATUS_WIDTH-1:0]             rsp_status,
   output logic signed [bsdl_pkg::DATA_WIDTH-1:0]        rsp_entry,
   output logic                                          rsp_last
);

   import bsdl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // request sequencing
   bsdl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .stat     (stat),
      .cmd      (cmd)
   );

   // storage, walk engine and result registers
   bsdl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_type   (req_type),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_entry  (rsp_entry),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire
